// ----- src/euler_321_to_rotation_matrix_core_macros.svh -----
// Assertion macros used by the checker file.
`ifndef EULER_321_TO_ROTATION_MATRIX_CORE_MACROS_SVH
`define EULER_321_TO_ROTATION_MATRIX_CORE_MACROS_SVH

// Checked only while out of reset.
`define E321_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Checked at every edge, reset included.
`define E321_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ----- src/e321_pkg.sv -----
`default_nettype none
package e321_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int ENTRY_BITS    = 16;
  localparam int CORDIC_STAGES = 16;

  localparam int ATAN_LEN = 30;
  localparam int NUM_ITER = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
  localparam int FRAC     = 30;
  localparam int ZW       = 35;
  localparam int XW       = 33;
  localparam int QW       = 32;
  localparam int ANGLE_SH = 33 - ANGLE_BITS;
  localparam int ENT_SH   = 32 - ENTRY_BITS;

  localparam logic signed [ZW-1:0] HALF_PI = 35'sd1686629713;
  localparam logic signed [ZW-1:0] PI      = 35'sd3373259426;
  localparam logic signed [XW-1:0] GAIN    = 33'sd652032874;

  localparam logic signed [ZW-1:0] ATAN_TAB [ATAN_LEN] = '{
    35'sh3243F6A8, 35'sh1DAC6705, 35'sh0FADBAFC, 35'sh07F56EA6, 35'sh03FEAB76,
    35'sh01FFD55B, 35'sh00FFFAAA, 35'sh007FFF55, 35'sh003FFFEA, 35'sh001FFFFD,
    35'sh000FFFFF, 35'sh0007FFFF, 35'sh0003FFFF, 35'sh0001FFFF, 35'sh0000FFFF,
    35'sh00007FFF, 35'sh00003FFF, 35'sh00001FFF, 35'sh00000FFF, 35'sh000007FF,
    35'sh000003FF, 35'sh000001FF, 35'sh000000FF, 35'sh0000007F, 35'sh0000003F,
    35'sh0000001F, 35'sh0000000F, 35'sh00000008, 35'sh00000004, 35'sh00000002
  };

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] roll_angle;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] yaw_angle;
  } angles_t;

  typedef struct packed {
    logic signed [ENTRY_BITS-1:0] row0_col0;
    logic signed [ENTRY_BITS-1:0] row0_col1;
    logic signed [ENTRY_BITS-1:0] row0_col2;
    logic signed [ENTRY_BITS-1:0] row1_col0;
    logic signed [ENTRY_BITS-1:0] row1_col1;
    logic signed [ENTRY_BITS-1:0] row1_col2;
    logic signed [ENTRY_BITS-1:0] row2_col0;
    logic signed [ENTRY_BITS-1:0] row2_col1;
    logic signed [ENTRY_BITS-1:0] row2_col2;
  } rmat_t;

  typedef struct packed {
    logic signed [ZW-1:0] z;
    logic                 neg_cos;
  } fold_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic                 neg_cos;
  } rot_t;

endpackage
`default_nettype wire

// ----- src/e321_fold.sv -----
`default_nettype none
module e321_fold (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  e321_pkg::angles_t          angles_i,
  output logic                       valid_o,
  output e321_pkg::fold_t [2:0]      fold_o
);
  import e321_pkg::*;

  logic                         valid_q;
  fold_t [2:0]                  fold_d, fold_q;
  logic signed [ANGLE_BITS-1:0] ang [3];
  logic signed [ZW-1:0]         z;

  always_comb begin
    ang[0] = angles_i.roll_angle;
    ang[1] = angles_i.pitch_angle;
    ang[2] = angles_i.yaw_angle;
    z      = '0;
    for (int k = 0; k < 3; k++) begin
      z = ZW'(ang[k]) <<< ANGLE_SH;
      if (z > HALF_PI) begin
        fold_d[k].z       = PI - z;
        fold_d[k].neg_cos = 1'b1;
      end else if (z < -HALF_PI) begin
        fold_d[k].z       = -PI - z;
        fold_d[k].neg_cos = 1'b1;
      end else begin
        fold_d[k].z       = z;
        fold_d[k].neg_cos = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fold_q <= fold_d;
    end
  end

  assign valid_o = valid_q;
  assign fold_o  = fold_q;

endmodule
`default_nettype wire

// ----- src/e321_cordic.sv -----
`default_nettype none
module e321_cordic (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  e321_pkg::fold_t [2:0]      fold_i,
  output logic                       valid_o,
  output e321_pkg::rot_t [2:0]       rot_o
);
  import e321_pkg::*;

  logic                 v_q  [NUM_ITER];
  logic signed [XW-1:0] x_p  [NUM_ITER][3];
  logic signed [XW-1:0] y_p  [NUM_ITER][3];
  logic signed [ZW-1:0] z_p  [NUM_ITER][3];
  logic                 n_p  [NUM_ITER][3];
  logic signed [XW-1:0] x_d  [NUM_ITER][3];
  logic signed [XW-1:0] y_d  [NUM_ITER][3];
  logic signed [ZW-1:0] z_d  [NUM_ITER][3];
  logic signed [XW-1:0] x_q  [NUM_ITER][3];
  logic signed [XW-1:0] y_q  [NUM_ITER][3];
  logic signed [ZW-1:0] z_q  [NUM_ITER][3];
  logic                 n_q  [NUM_ITER][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      x_p[0][k] = GAIN;
      y_p[0][k] = '0;
      z_p[0][k] = fold_i[k].z;
      n_p[0][k] = fold_i[k].neg_cos;
    end
    for (int i = 1; i < NUM_ITER; i++) begin
      for (int k = 0; k < 3; k++) begin
        x_p[i][k] = x_q[i-1][k];
        y_p[i][k] = y_q[i-1][k];
        z_p[i][k] = z_q[i-1][k];
        n_p[i][k] = n_q[i-1][k];
      end
    end
    for (int i = 0; i < NUM_ITER; i++) begin
      for (int k = 0; k < 3; k++) begin
        if (!z_p[i][k][ZW-1]) begin
          x_d[i][k] = x_p[i][k] - (y_p[i][k] >>> i);
          y_d[i][k] = y_p[i][k] + (x_p[i][k] >>> i);
          z_d[i][k] = z_p[i][k] - ATAN_TAB[i];
        end else begin
          x_d[i][k] = x_p[i][k] + (y_p[i][k] >>> i);
          y_d[i][k] = y_p[i][k] - (x_p[i][k] >>> i);
          z_d[i][k] = z_p[i][k] + ATAN_TAB[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ITER; i++) begin
        v_q[i] <= 1'b0;
      end
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int i = 1; i < NUM_ITER; i++) begin
        v_q[i] <= v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NUM_ITER; i++) begin
        for (int k = 0; k < 3; k++) begin
          x_q[i][k] <= x_d[i][k];
          y_q[i][k] <= y_d[i][k];
          z_q[i][k] <= z_d[i][k];
          n_q[i][k] <= n_p[i][k];
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rot_o[k].x       = x_q[NUM_ITER-1][k];
      rot_o[k].y       = y_q[NUM_ITER-1][k];
      rot_o[k].neg_cos = n_q[NUM_ITER-1][k];
    end
  end

  assign valid_o = v_q[NUM_ITER-1];

endmodule
`default_nettype wire

// ----- src/e321_mat.sv -----
`default_nettype none
module e321_mat (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  e321_pkg::rot_t [2:0]       rot_i,
  output logic                       valid_o,
  output e321_pkg::rmat_t            rmat_o
);
  import e321_pkg::*;

  localparam logic signed [2*QW-1:0] MUL_RND =
    {{(2*QW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
  localparam logic signed [QW+1:0] ENT_RND = (QW+2)'((2**ENT_SH) / 2);
  localparam logic signed [QW+1:0] ENT_LIM = (QW+2)'(2**(ENTRY_BITS-2));

  function automatic logic signed [QW-1:0] mulq(input logic signed [QW-1:0] a,
                                                 input logic signed [QW-1:0] b);
    logic signed [2*QW-1:0] p;
    p = a * b;
    p = p + MUL_RND;
    return p[FRAC+QW-1:FRAC];
  endfunction

  function automatic logic signed [QW:0] add2(input logic signed [QW-1:0] a,
                                               input logic signed [QW-1:0] b);
    return {a[QW-1], a} + {b[QW-1], b};
  endfunction

  function automatic logic signed [ENTRY_BITS-1:0] entry(input logic signed [QW:0] v);
    logic signed [QW+1:0] w;
    w = {v[QW], v} + ENT_RND;
    w = w >>> ENT_SH;
    if (w > ENT_LIM) begin
      w = ENT_LIM;
    end else if (w < -ENT_LIM) begin
      w = -ENT_LIM;
    end
    return w[ENTRY_BITS-1:0];
  endfunction

  function automatic logic signed [QW:0] ext(input logic signed [QW-1:0] a);
    return {a[QW-1], a};
  endfunction

  logic                 v0_q, v1_q, v2_q, v3_q;
  logic signed [QW-1:0] s_q [3];
  logic signed [QW-1:0] c_q [3];
  logic signed [XW-1:0] cneg [3];

  // First product level.
  logic signed [QW-1:0] c2c3_q, c2s3_q, t1_q, t2_q, c1s3_q, c1c3_q;
  logic signed [QW-1:0] s1s3_q, s1c3_q, s1c2_q, c1c2_q, s2_q, c3_q, s3_q;

  // Second product level.
  logic signed [QW-1:0] e0_q, e1_q, e2_q, e5_q, e8_q;
  logic signed [QW-1:0] t1c3_q, t1s3_q, t2c3_q, t2s3_q;
  logic signed [QW-1:0] c1s3b_q, c1c3b_q, s1s3b_q, s1c3b_q;

  rmat_t rmat_d, rmat_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cneg[k] = rot_i[k].neg_cos ? -rot_i[k].x : rot_i[k].x;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        s_q[k] <= rot_i[k].y[QW-1:0];
        c_q[k] <= cneg[k][QW-1:0];
      end

      c2c3_q <= mulq(c_q[1], c_q[2]);
      c2s3_q <= mulq(c_q[1], s_q[2]);
      t1_q   <= mulq(s_q[0], s_q[1]);
      t2_q   <= mulq(c_q[0], s_q[1]);
      c1s3_q <= mulq(c_q[0], s_q[2]);
      c1c3_q <= mulq(c_q[0], c_q[2]);
      s1s3_q <= mulq(s_q[0], s_q[2]);
      s1c3_q <= mulq(s_q[0], c_q[2]);
      s1c2_q <= mulq(s_q[0], c_q[1]);
      c1c2_q <= mulq(c_q[0], c_q[1]);
      s2_q   <= s_q[1];
      c3_q   <= c_q[2];
      s3_q   <= s_q[2];

      e0_q    <= c2c3_q;
      e1_q    <= -c2s3_q;
      e2_q    <= s2_q;
      e5_q    <= -s1c2_q;
      e8_q    <= c1c2_q;
      t1c3_q  <= mulq(t1_q, c3_q);
      t1s3_q  <= mulq(t1_q, s3_q);
      t2c3_q  <= mulq(t2_q, c3_q);
      t2s3_q  <= mulq(t2_q, s3_q);
      c1s3b_q <= c1s3_q;
      c1c3b_q <= c1c3_q;
      s1s3b_q <= s1s3_q;
      s1c3b_q <= s1c3_q;

      rmat_q <= rmat_d;
    end
  end

  always_comb begin
    rmat_d.row0_col0 = entry(ext(e0_q));
    rmat_d.row0_col1 = entry(ext(e1_q));
    rmat_d.row0_col2 = entry(ext(e2_q));
    rmat_d.row1_col0 = entry(add2(t1c3_q, c1s3b_q));
    rmat_d.row1_col1 = entry(add2(-t1s3_q, c1c3b_q));
    rmat_d.row1_col2 = entry(ext(e5_q));
    rmat_d.row2_col0 = entry(add2(-t2c3_q, s1s3b_q));
    rmat_d.row2_col1 = entry(add2(t2s3_q, s1c3b_q));
    rmat_d.row2_col2 = entry(ext(e8_q));
  end

  assign valid_o = v3_q;
  assign rmat_o  = rmat_q;

endmodule
`default_nettype wire

// ----- src/euler_321_to_rotation_matrix_core.sv -----
// An accepted transaction passes the fold register, the CORDIC pipeline and the matrix registers in turn.
// Throughput: one transaction per cycle unless stalled, set by the fully unrolled CORDIC pipeline.
// A stalled result holds the whole pipeline; bubbles flow through in step with data.
// Reset (rst_ni low, asynchronous) clears all valid bits; data registers are not reset.
`default_nettype none
module euler_321_to_rotation_matrix_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  e321_pkg::angles_t    angles_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output e321_pkg::rmat_t      rmat_o
);
  import e321_pkg::*;

  logic        en;
  logic        fold_valid, rot_valid;
  fold_t [2:0] fold;
  rot_t  [2:0] rot;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  e321_fold u_fold (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .angles_i (angles_i),
    .valid_o  (fold_valid),
    .fold_o   (fold)
  );

  e321_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fold_valid),
    .fold_i  (fold),
    .valid_o (rot_valid),
    .rot_o   (rot)
  );

  e321_mat u_mat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rot_valid),
    .rot_i   (rot),
    .valid_o (out_valid_o),
    .rmat_o  (rmat_o)
  );

endmodule
`default_nettype wire

// ----- src/e321_chk.sv -----
`default_nettype none
`include "euler_321_to_rotation_matrix_core_macros.svh"
module e321_chk (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input e321_pkg::rmat_t      rmat_o
);
  import e321_pkg::*;

  localparam logic signed [ENTRY_BITS-1:0] LIM = ENTRY_BITS'(2**(ENTRY_BITS-2));

  `E321_ASSERT_ALWAYS(a_reset_clears, clk_i, !rst_ni |=> !out_valid_o)

  `E321_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(rmat_o))

  `E321_ASSERT(a_backpressure, clk_i, rst_ni, out_valid_o && out_stall_i |-> in_stall_o)

  `E321_ASSERT(a_saturated, clk_i, rst_ni,
    out_valid_o |-> rmat_o.row1_col1 <= LIM && rmat_o.row1_col1 >= -LIM &&
    rmat_o.row2_col0 <= LIM && rmat_o.row2_col0 >= -LIM)

endmodule

bind euler_321_to_rotation_matrix_core e321_chk u_chk (.*);
`default_nettype wire
